[hw/rtl/utf8dec_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder package
// Shared constants, the result record type and helpers for the decoder.
// ----------------------------------------------------------------------------
package utf8dec_pkg;

  // Default number of entries in the result queue (three or more).
  localparam int unsigned ResQueueDepth = 8;

  // Byte class masks and patterns.
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;

  // Payload masks.
  localparam logic [7:0] Lead2Bits = 8'h1F;
  localparam logic [7:0] Lead3Bits = 8'h0F;
  localparam logic [7:0] ContBits  = 8'h3F;

  // Held byte count codes.
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldLead = 2'd1;
  localparam logic [1:0] HeldBoth = 2'd2;

  // One result item.
  typedef struct packed {
    logic [15:0] code_point;
    logic        raw_passthrough;
    logic        last_of_run;
    logic        string_done;
  } res_t;

  // Build a result with the run markers cleared.
  function automatic res_t make_res(logic [15:0] cp, logic raw);
    res_t r;
    r.code_point      = cp;
    r.raw_passthrough = raw;
    r.last_of_run     = 1'b0;
    r.string_done     = 1'b0;
    return r;
  endfunction

  // Raw byte, zero-extended, marked as passed through.
  function automatic res_t raw_res(logic [7:0] b);
    return make_res({8'h00, b}, 1'b1);
  endfunction

endpackage

[hw/rtl/utf8_to_ucs2_decoder_top.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder, top level
// Decodes a UTF-8 byte stream into 16-bit code points, one byte per cycle.
// ----------------------------------------------------------------------------
// The decoder accepts one UTF-8 byte per clock cycle and produces zero to three
// 16-bit results for each byte, which are delivered one per cycle from a small
// result queue of RES_DEPTH entries. A byte is decoded in the cycle it is
// transferred, and its results are written to the queue tail, behind any earlier results.
// The input is held off only while fewer than three queue entries are free; as
// a string never yields more results than bytes, the queue sustains one byte
// per cycle when the output side takes one result per cycle. Bytes that cannot
// be decoded are passed through raw, zero-extended, with tuser bit 0 set.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_top #(
  parameter int unsigned RES_DEPTH = utf8dec_pkg::ResQueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_string
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_point
  output logic [1:0]  out_tuser,  // [0] raw_passthrough, [1] last_of_run
  output logic        out_tlast   // string_done
);

  localparam int unsigned PtrW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RES_DEPTH + 1);

  // Held sequence state.
  logic [1:0] held_count_r, held_count_nxt;
  logic [7:0] held_lead_r, held_lead_nxt;
  logic [7:0] held_cont_r, held_cont_nxt;

  // Result queue.
  utf8dec_pkg::res_t res_mem_r [RES_DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  // Decode results for the current byte.
  utf8dec_pkg::res_t slot [3];
  logic [1:0]        wr_n;
  logic [PtrW-1:0]   widx [4];

  logic in_xfer;
  logic out_xfer;
  logic is_cont;
  logic is_lead2;
  logic is_lead3;
  logic held_two;

  assign in_tready = (cnt_r <= CntW'(RES_DEPTH - 3));
  assign in_xfer   = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_xfer  = out_tvalid && out_tready;

  assign is_cont  = (in_tdata & utf8dec_pkg::ContMask)  == utf8dec_pkg::ContPat;
  assign is_lead2 = (in_tdata & utf8dec_pkg::Lead2Mask) == utf8dec_pkg::Lead2Pat;
  assign is_lead3 = (in_tdata & utf8dec_pkg::Lead3Mask) == utf8dec_pkg::Lead3Pat;
  // A count of three is treated like two.
  assign held_two = held_count_r[1];

  // Byte decode: up to three results appended in order.
  always_comb begin
    held_count_nxt = held_count_r;
    held_lead_nxt  = held_lead_r;
    held_cont_nxt  = held_cont_r;
    wr_n           = 2'd0;
    for (int k = 0; k < 3; k++) begin
      slot[k] = utf8dec_pkg::make_res(16'h0000, 1'b0);
    end

    if (in_xfer) begin
      if (held_count_r != utf8dec_pkg::HeldNone && is_cont) begin
        // Continuation byte extends the held sequence.
        if ((held_lead_r & utf8dec_pkg::Lead2Mask) == utf8dec_pkg::Lead2Pat) begin
          slot[wr_n] = utf8dec_pkg::make_res(
              {5'd0, held_lead_r[4:0] & utf8dec_pkg::Lead2Bits[4:0],
               in_tdata[5:0] & utf8dec_pkg::ContBits[5:0]}, 1'b0);
          wr_n = wr_n + 2'd1;
          held_count_nxt = utf8dec_pkg::HeldNone;
        end else if (!held_two) begin
          held_cont_nxt  = in_tdata;
          held_count_nxt = utf8dec_pkg::HeldBoth;
        end else begin
          slot[wr_n] = utf8dec_pkg::make_res(
              {held_lead_r[3:0] & utf8dec_pkg::Lead3Bits[3:0],
               held_cont_r[5:0] & utf8dec_pkg::ContBits[5:0],
               in_tdata[5:0] & utf8dec_pkg::ContBits[5:0]}, 1'b0);
          wr_n = wr_n + 2'd1;
          held_count_nxt = utf8dec_pkg::HeldNone;
        end
      end else begin
        // Release anything held, then take the byte afresh.
        if (held_count_r != utf8dec_pkg::HeldNone) begin
          slot[wr_n] = utf8dec_pkg::raw_res(held_lead_r);
          wr_n = wr_n + 2'd1;
          if (held_two) begin
            slot[wr_n] = utf8dec_pkg::raw_res(held_cont_r);
            wr_n = wr_n + 2'd1;
          end
        end
        held_count_nxt = utf8dec_pkg::HeldNone;
        if (!in_tdata[7]) begin
          slot[wr_n] = utf8dec_pkg::make_res({8'h00, in_tdata}, 1'b0);
          wr_n = wr_n + 2'd1;
        end else if (is_lead2 || is_lead3) begin
          held_lead_nxt  = in_tdata;
          held_count_nxt = utf8dec_pkg::HeldLead;
        end else begin
          slot[wr_n] = utf8dec_pkg::raw_res(in_tdata);
          wr_n = wr_n + 2'd1;
        end
      end

      // End of string flushes whatever is still held.
      if (in_tlast) begin
        if (held_count_nxt != utf8dec_pkg::HeldNone) begin
          slot[wr_n] = utf8dec_pkg::raw_res(held_lead_nxt);
          wr_n = wr_n + 2'd1;
          if (held_count_nxt[1]) begin
            slot[wr_n] = utf8dec_pkg::raw_res(held_cont_nxt);
            wr_n = wr_n + 2'd1;
          end
        end
        held_count_nxt = utf8dec_pkg::HeldNone;
      end

      // Mark the final result of this byte.
      if (wr_n != 2'd0) begin
        slot[wr_n - 2'd1].last_of_run = 1'b1;
        slot[wr_n - 2'd1].string_done = in_tlast;
      end
    end
  end

  // Queue write addresses with wrap-around.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [PtrW:0] sum;
      sum = {1'b0, wr_ptr_r} + (PtrW + 1)'(k);
      if (sum >= (PtrW + 1)'(RES_DEPTH)) begin
        sum = sum - (PtrW + 1)'(RES_DEPTH);
      end
      widx[k] = sum[PtrW-1:0];
    end
  end

  // Queue pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = widx[wr_n];
    rd_ptr_nxt = rd_ptr_r;
    if (out_xfer) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(RES_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    cnt_nxt = cnt_r + CntW'(wr_n) - CntW'(out_xfer);
  end

  // Control registers and held bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= utf8dec_pkg::HeldNone;
      held_lead_r  <= 8'h00;
      held_cont_r  <= 8'h00;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      held_count_r <= held_count_nxt;
      held_lead_r  <= held_lead_nxt;
      held_cont_r  <= held_cont_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < wr_n) begin
        res_mem_r[widx[k]] <= slot[k];
      end
    end
  end

  // Result output from the queue head.
  assign out_tdata = res_mem_r[rd_ptr_r].code_point;
  assign out_tuser = {res_mem_r[rd_ptr_r].last_of_run,
                      res_mem_r[rd_ptr_r].raw_passthrough};
  assign out_tlast = res_mem_r[rd_ptr_r].string_done;

  // Occupancy never exceeds the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(RES_DEPTH))
    else $error("result queue occupancy beyond its depth");

  // Two held bytes only ever follow a three-byte lead.
  a_held_two: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r == utf8dec_pkg::HeldBoth |-> held_lead_r[7:4] == 4'hE)
    else $error("continuation held behind a lead that is not three-byte");

  // Nothing stays held after the last byte of a string.
  a_eos_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> held_count_r == utf8dec_pkg::HeldNone)
    else $error("bytes still held after end of string");

  // Raw results carry a zero-extended byte.
  a_raw_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[15:8] == 8'h00)
    else $error("raw result wider than a byte");

endmodule

[verif/utf8_to_ucs2_decoder_top_tb.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder testbench
// Streams UTF-8 strings into the decoder, predicts each 16-bit result from its
// own copy of the held-byte state, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tlast;   // end_of_string
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] code_point
  logic [1:0]  out_tuser;  // [0] raw_passthrough, [1] last_of_run
  logic        out_tlast;  // string_done

  // Predictor state: bytes held while a sequence is being assembled.
  logic [1:0]  held_cnt;
  logic [7:0]  held_lead_byte;
  logic [7:0]  held_cont_byte;

  // Results of the current byte, and all results still to arrive.
  utf8dec_pkg::res_t byte_results[$];
  utf8dec_pkg::res_t code_points_due[$];
  logic [7:0]        string_bytes[$];

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  bit          in_idle_en;
  bit          out_idle_en;

  utf8_to_ucs2_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle limit guards against a stalled handshake or a missing result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: cycle limit reached, %0d results outstanding", $time,
               code_points_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void put_result(logic [15:0] cp, logic raw);
    utf8dec_pkg::res_t r;
    r.code_point      = cp;
    r.raw_passthrough = raw;
    r.last_of_run     = 1'b0;
    r.string_done     = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void drop_held();
    held_cnt       = utf8dec_pkg::HeldNone;
    held_lead_byte = 8'h00;
    held_cont_byte = 8'h00;
  endfunction

  // A byte seen with nothing held: ASCII goes straight out, a two- or
  // three-byte lead is held, and anything else passes through raw.
  function automatic void start_fresh(logic [7:0] b);
    if (!b[7]) begin
      put_result({8'h00, b}, 1'b0);
    end else if ((b & utf8dec_pkg::Lead2Mask) == utf8dec_pkg::Lead2Pat ||
                 (b & utf8dec_pkg::Lead3Mask) == utf8dec_pkg::Lead3Pat) begin
      held_lead_byte = b;
      held_cnt       = utf8dec_pkg::HeldLead;
    end else begin
      put_result({8'h00, b}, 1'b1);
    end
  endfunction

  // Whatever is held goes out raw, the lead before the continuation.
  function automatic void flush_held();
    if (held_cnt != utf8dec_pkg::HeldNone) begin
      put_result({8'h00, held_lead_byte}, 1'b1);
      if (held_cnt >= utf8dec_pkg::HeldBoth) put_result({8'h00, held_cont_byte}, 1'b1);
    end
    drop_held();
  endfunction

  // Works out the results of one accepted byte and queues them.
  function automatic void decode_byte(logic [7:0] b, logic eos);
    byte_results.delete();
    if (held_cnt == utf8dec_pkg::HeldNone) begin
      start_fresh(b);
    end else if ((b & utf8dec_pkg::ContMask) == utf8dec_pkg::ContPat) begin
      if ((held_lead_byte & utf8dec_pkg::Lead2Mask) == utf8dec_pkg::Lead2Pat) begin
        put_result((16'(held_lead_byte & utf8dec_pkg::Lead2Bits) << 6) |
                   16'(b & utf8dec_pkg::ContBits), 1'b0);
        drop_held();
      end else if (held_cnt == utf8dec_pkg::HeldLead) begin
        held_cont_byte = b;
        held_cnt       = utf8dec_pkg::HeldBoth;
      end else begin
        put_result((16'(held_lead_byte & utf8dec_pkg::Lead3Bits) << 12) |
                   (16'(held_cont_byte & utf8dec_pkg::ContBits) << 6) |
                   16'(b & utf8dec_pkg::ContBits), 1'b0);
        drop_held();
      end
    end else begin
      // The held sequence is broken: release it and start over on this byte.
      flush_held();
      start_fresh(b);
    end
    if (eos) flush_held();
    if (byte_results.size() > 0) begin
      byte_results[byte_results.size()-1].last_of_run = 1'b1;
      byte_results[byte_results.size()-1].string_done = eos;
    end
    foreach (byte_results[i]) code_points_due.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Each result transfer is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    utf8dec_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (code_points_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cp=%h user=%b last=%b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = code_points_due.pop_front();
        check_field("code_point", want.code_point, out_tdata);
        check_field("raw_passthrough", 16'(want.raw_passthrough), 16'(out_tuser[0]));
        check_field("last_of_run", 16'(want.last_of_run), 16'(out_tuser[1]));
        check_field("string_done", 16'(want.string_done), 16'(out_tlast));
      end
    end
  end

  // Result-side backpressure: random stalls while enabled, otherwise ready.
  initial begin
    int unsigned n;
    out_tready = 1'b0;
    forever begin
      if (out_idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        repeat (n) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) begin
          @(negedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Sends one byte, with an optional idle burst first, and predicts its results
  // once the transfer has taken place.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, eos);
    bytes_sent++;
  endtask

  // Sends the assembled string with the end flag on its final byte.
  task automatic send_string();
    foreach (string_bytes[i]) send_byte(string_bytes[i], i == string_bytes.size() - 1);
  endtask

  // Builds a string of mostly well-formed characters with random content; a
  // share of the characters are random bytes or sequences cut short.
  function automatic void build_string(int unsigned chars, int unsigned noise_pct);
    int unsigned kind;
    string_bytes.delete();
    for (int i = 0; i < chars; i++) begin
      kind = $urandom_range(0, 2);
      if ($urandom_range(0, 99) < noise_pct) begin
        case (kind)
          0: string_bytes.push_back(8'($urandom_range(0, 255)));
          1: string_bytes.push_back(8'($urandom_range(8'hC0, 8'hEF)));
          default: begin
            string_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            string_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
          end
        endcase
      end else begin
        case (kind)
          0: string_bytes.push_back(8'($urandom_range(0, 8'h7F)));
          1: begin
            string_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            string_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
          end
          default: begin
            string_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            string_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            string_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
          end
        endcase
      end
    end
  endfunction

  // Field extremes, every sequence length and each way a sequence can fail.
  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // Smallest and largest two-byte sequences.
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // Smallest and largest three-byte sequences.
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // Stray continuation, then leads of four bytes and more.
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    // Lead followed by a byte that is not a continuation.
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    // Lead and continuation held when the sequence breaks.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b0);
    // Broken by a new lead on the final byte: three results from one transfer.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hC3, 1'b1);
    // Lead cut short by the end of the string, then a lone ASCII string.
    send_byte(8'hD0, 1'b1);
    send_byte(8'h41, 1'b1);
  endtask

  // Random strings under idling on both sides.
  task automatic test_random_strings();
    int unsigned target;
    target = bytes_sent + 130;
    while (bytes_sent < target) begin
      build_string($urandom_range(1, 8), 15);
      send_string();
    end
  endtask

  // Unstructured bytes with random string ends.
  task automatic test_byte_noise();
    repeat (50) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
  endtask

  // Strings at full rate with no idling on either side.
  task automatic test_full_rate();
    int unsigned target;
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    target = bytes_sent + 40;
    while (bytes_sent < target) begin
      build_string($urandom_range(1, 8), 10);
      send_string();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    bytes_sent  = 0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    drop_held();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_strings();
    test_byte_noise();
    test_full_rate();

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Let every outstanding result arrive, then watch for stray ones.
    while (code_points_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/utf8dec_pkg.sv
hw/rtl/utf8_to_ucs2_decoder_top.sv
verif/utf8_to_ucs2_decoder_top_tb.sv
